// ===== hdl/hrdbs_pkg.sv =====
// Shared types and constants for the HID report descriptor button scan core.
package hrdbs_pkg;

    typedef struct packed {
        logic [7:0] desc_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0] parse_status;
        logic [8:0] button_total;
        logic       has_left;
        logic       has_right;
    } t_out_item;

    typedef struct packed {
        logic       final_byte;
        logic [7:0] desc_byte;
        logic       long_tag;
        logic [1:0] kind;
        logic [3:0] code;
        logic [2:0] length;
    } t_entry;

    localparam logic [1:0]  ST_OK        = 2'd0;
    localparam logic [1:0]  ST_TRUNCATED = 2'd1;
    localparam logic [1:0]  ST_LONG      = 2'd2;

    localparam logic [3:0]  TAG_LONG     = 4'hf;
    localparam logic [1:0]  KIND_GLOBAL  = 2'd1;
    localparam logic [1:0]  KIND_LOCAL   = 2'd2;
    localparam logic [3:0]  CODE_PAGE    = 4'd0;
    localparam logic [3:0]  CODE_MIN     = 4'd1;
    localparam logic [3:0]  CODE_MAX     = 4'd2;
    localparam logic [31:0] PAGE_BUTTON  = 32'd9;
    localparam logic [1:0]  SIZE_FOUR    = 2'd3;

endpackage

// ===== hdl/hrdbs_front.sv =====
// Front end: input handshake and prefix-field decode of each descriptor byte.
module hrdbs_front (
    input  logic                i_in_valid,
    input  hrdbs_pkg::t_in_item i_in_item,
    input  logic                i_queue_full,
    output logic                o_in_stall,
    output logic                o_push,
    output hrdbs_pkg::t_entry   o_entry
);

    assign o_in_stall = i_queue_full;
    assign o_push     = i_in_valid & ~i_queue_full;

    always_comb begin
        o_entry.final_byte = i_in_item.final_byte;
        o_entry.desc_byte  = i_in_item.desc_byte;
        o_entry.kind       = i_in_item.desc_byte[3:2];
        o_entry.code       = i_in_item.desc_byte[7:4];
        o_entry.long_tag   = (i_in_item.desc_byte[7:4] == hrdbs_pkg::TAG_LONG);
        if (i_in_item.desc_byte[1:0] == hrdbs_pkg::SIZE_FOUR) begin
            o_entry.length = 3'd4;
        end else begin
            o_entry.length = {1'b0, i_in_item.desc_byte[1:0]};
        end
    end

endmodule

// ===== hdl/hrdbs_queue.sv =====
// Two-entry queue between the decode front end and the parse back end.
module hrdbs_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  hrdbs_pkg::t_entry i_entry,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output hrdbs_pkg::t_entry o_entry
);

    hrdbs_pkg::t_entry r_mem [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ===== hdl/hrdbs_back.sv =====
// Back end: item parser state machine, button range capture and result register.
module hrdbs_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  hrdbs_pkg::t_entry    i_q_entry,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output hrdbs_pkg::t_out_item o_out_item
);

    typedef enum logic [2:0] {
        PH_PREFIX   = 3'd0,
        PH_SHORT    = 3'd1,
        PH_LONGLEN  = 3'd2,
        PH_LONGTAG  = 3'd3,
        PH_LONGDATA = 3'd4
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_kind, n_kind;
    logic [3:0]  r_code, n_code;
    logic [2:0]  r_length, n_length;
    logic [7:0]  r_remaining, n_remaining;
    logic [31:0] r_accum, n_accum;
    logic [1:0]  r_pos, n_pos;
    logic        r_on_page, n_on_page;
    logic [7:0]  r_low, n_low;
    logic [7:0]  r_high, n_high;
    logic [1:0]  r_err, n_err;
    logic        r_out_valid;
    hrdbs_pkg::t_out_item r_out_item;
    hrdbs_pkg::t_out_item n_out_item;

    logic        a_en;
    logic [1:0]  a_kind;
    logic [3:0]  a_code;
    logic [2:0]  a_len;
    logic [31:0] a_val;
    logic [31:0] shifted;
    logic [8:0]  total;

    assign o_pop       = i_q_valid & (~i_q_entry.final_byte | ~r_out_valid | ~i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign shifted     = {24'd0, i_q_entry.desc_byte} << {r_pos, 3'b000};

    always_comb begin
        n_phase     = r_phase;
        n_kind      = r_kind;
        n_code      = r_code;
        n_length    = r_length;
        n_remaining = r_remaining;
        n_accum     = r_accum;
        n_pos       = r_pos;
        n_on_page   = r_on_page;
        n_low       = r_low;
        n_high      = r_high;
        n_err       = r_err;
        a_en        = 1'b0;
        a_kind      = r_kind;
        a_code      = r_code;
        a_len       = r_length;
        a_val       = r_accum;

        if (r_err == hrdbs_pkg::ST_OK) begin
            unique case (r_phase)
                PH_SHORT: begin
                    n_accum     = r_accum | shifted;
                    n_pos       = r_pos + 2'd1;
                    n_remaining = r_remaining - 8'd1;
                    if (n_remaining == 8'd0) begin
                        a_en    = 1'b1;
                        a_val   = n_accum;
                        n_phase = PH_PREFIX;
                    end
                end
                PH_LONGLEN: begin
                    n_remaining = i_q_entry.desc_byte;
                    n_phase     = PH_LONGTAG;
                end
                PH_LONGTAG: begin
                    if (r_remaining == 8'd0) begin
                        n_err   = hrdbs_pkg::ST_LONG;
                        n_phase = PH_PREFIX;
                    end else begin
                        n_phase = PH_LONGDATA;
                    end
                end
                PH_LONGDATA: begin
                    n_remaining = r_remaining - 8'd1;
                    if (n_remaining == 8'd0) begin
                        n_err   = hrdbs_pkg::ST_LONG;
                        n_phase = PH_PREFIX;
                    end
                end
                default: begin
                    n_kind = i_q_entry.kind;
                    n_code = i_q_entry.code;
                    if (i_q_entry.long_tag) begin
                        n_phase = PH_LONGLEN;
                    end else begin
                        n_length = i_q_entry.length;
                        n_accum  = 32'd0;
                        n_pos    = 2'd0;
                        if (i_q_entry.length == 3'd0) begin
                            a_en    = 1'b1;
                            a_kind  = i_q_entry.kind;
                            a_code  = i_q_entry.code;
                            a_len   = 3'd0;
                            a_val   = 32'd0;
                            n_phase = PH_PREFIX;
                        end else begin
                            n_remaining = {5'd0, i_q_entry.length};
                            n_phase     = PH_SHORT;
                        end
                    end
                end
            endcase
        end

        if (a_en) begin
            if (a_kind == hrdbs_pkg::KIND_GLOBAL && a_code == hrdbs_pkg::CODE_PAGE) begin
                n_on_page = (a_val == hrdbs_pkg::PAGE_BUTTON);
            end else if (a_kind == hrdbs_pkg::KIND_LOCAL && a_len != 3'd0 && r_on_page) begin
                if (a_code == hrdbs_pkg::CODE_MIN) begin
                    n_low = a_val[7:0];
                end else if (a_code == hrdbs_pkg::CODE_MAX) begin
                    n_high = a_val[7:0];
                end
            end
        end

        if (n_err != hrdbs_pkg::ST_OK) begin
            n_out_item.parse_status = n_err;
        end else if (n_phase != PH_PREFIX) begin
            n_out_item.parse_status = hrdbs_pkg::ST_TRUNCATED;
        end else begin
            n_out_item.parse_status = hrdbs_pkg::ST_OK;
        end
        if (n_out_item.parse_status == hrdbs_pkg::ST_OK && n_on_page && n_high >= n_low) begin
            total = {1'b0, n_high} - {1'b0, n_low} + 9'd1;
        end else begin
            total = 9'd0;
        end
        n_out_item.button_total = total;
        n_out_item.has_left     = (total != 9'd0);
        n_out_item.has_right    = (total > 9'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_PREFIX;
            r_kind      <= 2'd0;
            r_code      <= 4'd0;
            r_length    <= 3'd0;
            r_remaining <= 8'd0;
            r_accum     <= 32'd0;
            r_pos       <= 2'd0;
            r_on_page   <= 1'b0;
            r_low       <= 8'd0;
            r_high      <= 8'd0;
            r_err       <= hrdbs_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && i_q_entry.final_byte) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                if (i_q_entry.final_byte) begin
                    r_out_item  <= n_out_item;
                    r_phase     <= PH_PREFIX;
                    r_kind      <= 2'd0;
                    r_code      <= 4'd0;
                    r_length    <= 3'd0;
                    r_remaining <= 8'd0;
                    r_accum     <= 32'd0;
                    r_pos       <= 2'd0;
                    r_on_page   <= 1'b0;
                    r_low       <= 8'd0;
                    r_high      <= 8'd0;
                    r_err       <= hrdbs_pkg::ST_OK;
                end else begin
                    r_phase     <= n_phase;
                    r_kind      <= n_kind;
                    r_code      <= n_code;
                    r_length    <= n_length;
                    r_remaining <= n_remaining;
                    r_accum     <= n_accum;
                    r_pos       <= n_pos;
                    r_on_page   <= n_on_page;
                    r_low       <= n_low;
                    r_high      <= n_high;
                    r_err       <= n_err;
                end
            end
        end
    end

endmodule

// ===== hdl/hid_report_descriptor_button_scan_core.sv =====
// Top level of the HID report descriptor button scan core.
// Takes one descriptor byte per transaction and sustains one byte per clock while the parser
// is not stalled. Each byte is decoded and written into a two-entry queue, then the parser
// stage consumes one entry per cycle, so the result for the last byte is loaded from the queue
// head into the result register, which drives the output directly. The result sits in an
// output register, so the input keeps flowing while it waits; only a second last-byte held
// behind an untaken result stalls the parser.
module hid_report_descriptor_button_scan_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  hrdbs_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output hrdbs_pkg::t_out_item o_out_item
);

    logic              push;
    logic              pop;
    logic              queue_full;
    logic              q_valid;
    hrdbs_pkg::t_entry front_entry;
    hrdbs_pkg::t_entry q_entry;

    hrdbs_front u_front (
        .i_in_valid   (i_in_valid),
        .i_in_item    (i_in_item),
        .i_queue_full (queue_full),
        .o_in_stall   (o_in_stall),
        .o_push       (push),
        .o_entry      (front_entry)
    );

    hrdbs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    hrdbs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_entry   (q_entry),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== tb/hid_report_descriptor_button_scan_checker.sv =====
// Channel monitor, button scan predictor and result comparison for the scan core.
module hid_report_descriptor_button_scan_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  hrdbs_pkg::t_in_item  i_in_item,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  hrdbs_pkg::t_out_item i_out_item,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_byte_count,
    output int                   o_ok_count,
    output int                   o_trunc_count,
    output int                   o_long_count,
    output int                   o_widest
);

    typedef enum logic [2:0] {
        SCAN_PREFIX,
        SCAN_SHORT,
        SCAN_LONG_LEN,
        SCAN_LONG_TAG,
        SCAN_LONG_DATA
    } t_scan_phase;

    t_scan_phase phase;
    logic [1:0]  kind;
    logic [3:0]  code;
    logic [2:0]  length;
    logic [7:0]  remaining;
    logic [31:0] accum;
    logic [1:0]  pos;
    logic        page_flag;
    logic [7:0]  usage_lo;
    logic [7:0]  usage_hi;
    logic [1:0]  sticky;

    hrdbs_pkg::t_out_item expected_reports[$];
    int          fail_total  = 0;
    int          bytes_seen  = 0;
    int          ok_seen     = 0;
    int          trunc_seen  = 0;
    int          long_seen   = 0;
    int          widest_seen = 0;
    int          report_idx  = 0;

    initial begin
        o_fail_count  = 0;
        o_pending     = 0;
        o_byte_count  = 0;
        o_ok_count    = 0;
        o_trunc_count = 0;
        o_long_count  = 0;
        o_widest      = 0;
    end

    task automatic clear_scan();
        phase     = SCAN_PREFIX;
        kind      = '0;
        code      = '0;
        length    = '0;
        remaining = '0;
        accum     = '0;
        pos       = '0;
        page_flag = 1'b0;
        usage_lo  = '0;
        usage_hi  = '0;
        sticky    = hrdbs_pkg::ST_OK;
    endtask

    task automatic commit_item();
        if (kind == hrdbs_pkg::KIND_GLOBAL && code == hrdbs_pkg::CODE_PAGE) begin
            page_flag = (accum == hrdbs_pkg::PAGE_BUTTON);
        end else if (kind == hrdbs_pkg::KIND_LOCAL && length != 3'd0 && page_flag) begin
            if (code == hrdbs_pkg::CODE_MIN) begin
                usage_lo = accum[7:0];
            end else if (code == hrdbs_pkg::CODE_MAX) begin
                usage_hi = accum[7:0];
            end
        end
    endtask

    task automatic scan_byte(input hrdbs_pkg::t_in_item it, output bit got,
                             output hrdbs_pkg::t_out_item res);
        logic [1:0] st;
        logic [8:0] total;
        got = 1'b0;
        res = '0;
        if (sticky == hrdbs_pkg::ST_OK) begin
            case (phase)
                SCAN_SHORT: begin
                    accum = accum | (32'(it.desc_byte) << (8 * pos));
                    pos = pos + 2'd1;
                    remaining = remaining - 8'd1;
                    if (remaining == 8'd0) begin
                        commit_item();
                        phase = SCAN_PREFIX;
                    end
                end
                SCAN_LONG_LEN: begin
                    remaining = it.desc_byte;
                    phase = SCAN_LONG_TAG;
                end
                SCAN_LONG_TAG: begin
                    if (remaining == 8'd0) begin
                        sticky = hrdbs_pkg::ST_LONG;
                        phase = SCAN_PREFIX;
                    end else begin
                        phase = SCAN_LONG_DATA;
                    end
                end
                SCAN_LONG_DATA: begin
                    remaining = remaining - 8'd1;
                    if (remaining == 8'd0) begin
                        sticky = hrdbs_pkg::ST_LONG;
                        phase = SCAN_PREFIX;
                    end
                end
                default: begin
                    kind = it.desc_byte[3:2];
                    code = it.desc_byte[7:4];
                    if (code == hrdbs_pkg::TAG_LONG) begin
                        phase = SCAN_LONG_LEN;
                    end else begin
                        length = (it.desc_byte[1:0] == hrdbs_pkg::SIZE_FOUR)
                                 ? 3'd4 : {1'b0, it.desc_byte[1:0]};
                        accum = '0;
                        pos = '0;
                        if (length == 3'd0) begin
                            commit_item();
                            phase = SCAN_PREFIX;
                        end else begin
                            remaining = {5'd0, length};
                            phase = SCAN_SHORT;
                        end
                    end
                end
            endcase
        end
        if (it.final_byte) begin
            if (sticky != hrdbs_pkg::ST_OK) begin
                st = sticky;
            end else if (phase != SCAN_PREFIX) begin
                st = hrdbs_pkg::ST_TRUNCATED;
            end else begin
                st = hrdbs_pkg::ST_OK;
            end
            total = '0;
            if (st == hrdbs_pkg::ST_OK && page_flag && usage_hi >= usage_lo) begin
                total = {1'b0, usage_hi} - {1'b0, usage_lo} + 9'd1;
            end
            res.parse_status = st;
            res.button_total = total;
            res.has_left     = (total >= 9'd1);
            res.has_right    = (total > 9'd1);
            got = 1'b1;
            clear_scan();
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at result %0d: %s got %0d want %0d", report_idx, what, got, want);
        fail_total++;
    endtask

    always @(posedge i_clk) begin
        hrdbs_pkg::t_out_item want;
        hrdbs_pkg::t_out_item res;
        bit                   got;
        if (!i_rst_n) begin
            clear_scan();
            expected_reports.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_reports.size() == 0) begin
                    report_mismatch("result with nothing pending, status",
                                    i_out_item.parse_status, 0);
                end else begin
                    want = expected_reports.pop_front();
                    if (i_out_item.parse_status != want.parse_status)
                        report_mismatch("parse_status", i_out_item.parse_status,
                                        want.parse_status);
                    if (i_out_item.button_total != want.button_total)
                        report_mismatch("button_total", i_out_item.button_total,
                                        want.button_total);
                    if (i_out_item.has_left != want.has_left)
                        report_mismatch("has_left", i_out_item.has_left, want.has_left);
                    if (i_out_item.has_right != want.has_right)
                        report_mismatch("has_right", i_out_item.has_right, want.has_right);
                    case (want.parse_status)
                        hrdbs_pkg::ST_OK:        ok_seen++;
                        hrdbs_pkg::ST_TRUNCATED: trunc_seen++;
                        default:                 long_seen++;
                    endcase
                    if (int'(want.button_total) > widest_seen)
                        widest_seen = want.button_total;
                end
                report_idx++;
            end
            if (i_in_valid && !i_in_stall) begin
                bytes_seen++;
                scan_byte(i_in_item, got, res);
                if (got)
                    expected_reports.push_back(res);
            end
        end
        o_fail_count  <= fail_total;
        o_pending     <= expected_reports.size();
        o_byte_count  <= bytes_seen;
        o_ok_count    <= ok_seen;
        o_trunc_count <= trunc_seen;
        o_long_count  <= long_seen;
        o_widest      <= widest_seen;
    end

endmodule

// ===== tb/hid_report_descriptor_button_scan_core_tb.sv =====
// Stimulus, clock, reset and verdict for the HID report descriptor button scan core.
module hid_report_descriptor_button_scan_core_tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 1000;
    localparam int DRAIN_CYCLES = 8;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    hrdbs_pkg::t_in_item  in_item  = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    hrdbs_pkg::t_out_item out_item;

    int        fail_count;
    int        pending;
    int        byte_count;
    int        ok_count;
    int        trunc_count;
    int        long_count;
    int        widest;
    int        cycle_count = 0;
    int        burst_left  = 0;
    int        random_sent = 0;
    logic [7:0] desc_bytes[$];

    hid_report_descriptor_button_scan_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    hid_report_descriptor_button_scan_checker scan_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_item     (in_item),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_item    (out_item),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_byte_count  (byte_count),
        .o_ok_count    (ok_count),
        .o_trunc_count (trunc_count),
        .o_long_count  (long_count),
        .o_widest      (widest)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        in_item  <= '{desc_byte: b, final_byte: last};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst_left--;
    endtask

    task automatic send_descriptor();
        for (int i = 0; i < desc_bytes.size(); i++)
            send_byte(desc_bytes[i], i == desc_bytes.size() - 1);
        desc_bytes.delete();
    endtask

    task automatic push_short(input logic [1:0] kind, input logic [3:0] code,
                              input logic [1:0] szc, input logic [31:0] val);
        int n;
        n = (szc == hrdbs_pkg::SIZE_FOUR) ? 4 : szc;
        desc_bytes.push_back({code, kind, szc});
        for (int i = 0; i < n; i++)
            desc_bytes.push_back(val[8*i +: 8]);
    endtask

    task automatic push_long(input int len);
        desc_bytes.push_back({hrdbs_pkg::TAG_LONG, 4'($urandom)});
        desc_bytes.push_back(8'(len));
        desc_bytes.push_back(8'($urandom));
        for (int i = 0; i < len; i++)
            desc_bytes.push_back(8'($urandom));
    endtask

    task automatic push_filler();
        push_short(2'($urandom), 4'($urandom_range(0, 14)), 2'($urandom), $urandom);
    endtask

    function automatic logic [31:0] usage_value();
        return ($urandom_range(0, 2) == 0) ? $urandom : 32'($urandom_range(0, 20));
    endfunction

    task automatic push_buttons();
        logic [1:0] szc;
        bit         swap;
        repeat ($urandom_range(0, 2)) push_filler();
        if ($urandom_range(0, 4) != 0) begin
            szc = 2'($urandom_range(1, 3));
            push_short(hrdbs_pkg::KIND_GLOBAL, hrdbs_pkg::CODE_PAGE, szc,
                       hrdbs_pkg::PAGE_BUTTON);
        end else begin
            push_short(hrdbs_pkg::KIND_GLOBAL, hrdbs_pkg::CODE_PAGE, 2'($urandom),
                       $urandom_range(0, 12));
        end
        repeat ($urandom_range(0, 1)) push_filler();
        swap = ($urandom_range(0, 4) == 0);
        if (swap)
            push_short(hrdbs_pkg::KIND_LOCAL, hrdbs_pkg::CODE_MAX, 2'($urandom), usage_value());
        push_short(hrdbs_pkg::KIND_LOCAL, hrdbs_pkg::CODE_MIN, 2'($urandom), usage_value());
        if (!swap)
            push_short(hrdbs_pkg::KIND_LOCAL, hrdbs_pkg::CODE_MAX, 2'($urandom), usage_value());
        if ($urandom_range(0, 5) == 0)
            push_short(hrdbs_pkg::KIND_GLOBAL, hrdbs_pkg::CODE_PAGE, 2'd1,
                       $urandom_range(0, 12));
        repeat ($urandom_range(0, 2)) push_filler();
    endtask

    task automatic build_random_descriptor();
        int drop;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: push_buttons();
            6: begin
                repeat ($urandom_range(0, 2)) push_filler();
                push_long(($urandom_range(0, 9) == 0) ? $urandom_range(200, 255)
                                                      : $urandom_range(0, 5));
                repeat ($urandom_range(0, 4)) desc_bytes.push_back(8'($urandom));
            end
            7: begin
                push_buttons();
                drop = $urandom_range(1, 3);
                while (drop > 0 && desc_bytes.size() > 1) begin
                    void'(desc_bytes.pop_back());
                    drop--;
                end
            end
            8: repeat ($urandom_range(1, 10)) desc_bytes.push_back(8'($urandom));
            default: begin
                if ($urandom_range(0, 1) == 0)
                    push_filler();
                else
                    push_short(hrdbs_pkg::KIND_GLOBAL, hrdbs_pkg::CODE_PAGE, 2'd1,
                               hrdbs_pkg::PAGE_BUTTON);
            end
        endcase
    endtask

    initial begin
        int mode_count;
        int run;
        int pct;
        mode_count = 0;
        forever begin
            mode_count++;
            run = $urandom_range(10, 80);
            if (mode_count % 6 == 3) begin
                run = 300;
                pct = 100;
            end else begin
                case ($urandom_range(0, 2))
                    0:       pct = 0;
                    1:       pct = 50;
                    default: pct = 90;
                endcase
            end
            repeat (run) begin
                out_stall <= ($urandom_range(1, 100) <= pct);
                @(posedge clk);
            end
        end
    end

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // three buttons on the button page
        desc_bytes = '{8'h05, 8'h09, 8'h19, 8'h01, 8'h29, 8'h03};
        send_descriptor();
        desc_bytes = '{8'h00};
        send_descriptor();
        // complete long item of zero length, then a byte to ignore
        desc_bytes = '{8'hfe, 8'h00, 8'h00, 8'hff};
        send_descriptor();
        // four-byte item cut off at its prefix
        desc_bytes = '{8'h1b};
        send_descriptor();
        // full usage range
        desc_bytes = '{8'h05, 8'h09, 8'h19, 8'h00, 8'h29, 8'hff};
        send_descriptor();
        // long item cut off at its prefix
        desc_bytes = '{8'hff};
        send_descriptor();
        // maximum below minimum
        desc_bytes = '{8'h05, 8'h09, 8'h19, 8'h05, 8'h29, 8'h02};
        send_descriptor();

        while (random_sent < RANDOM_BYTES) begin
            build_random_descriptor();
            random_sent += desc_bytes.size();
            send_descriptor();
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("scanned %0d descriptor bytes in %0d cycles", byte_count, cycle_count);
        $display("reports: %0d clean (widest range %0d buttons), %0d cut short, %0d long item",
                 ok_count, widest, trunc_count, long_count);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
